FILE: rtl/fifo_queue_with_search_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO queue with search
// Shared property shapes for the checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define FQS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fqs: same-cycle check failed");

// next-cycle implication
`define FQS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fqs: next-cycle check failed");

`endif

FILE: rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// FIFO queue with search: package
// Sizes, operation and status codes, memory port structs and ring helper.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  typedef logic [1:0]              op_t;
  typedef logic [1:0]              status_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [DATA_W-1:0] word_t;

  localparam op_t OP_ENQ  = 2'd0;
  localparam op_t OP_SHOW = 2'd1;
  localparam op_t OP_DEQ  = 2'd2;
  localparam op_t OP_FIND = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_t;

  function automatic idx_t slot_at(idx_t head, cnt_t k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(k);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/fqs_mem.sv
// ----------------------------------------------------------------------------
// FIFO queue with search: entry store
// Ring storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fqs_mem (
  input  logic          clk,
  input  fqs_pkg::wr_t  wr,
  input  fqs_pkg::rd_t  rd,
  output fqs_pkg::word_t rdata
);
  import fqs_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

FILE: rtl/fifo_queue_with_search_core.sv
// Enqueue, and any operation on an empty queue: result strobed the cycle after start.
// Dequeue: busy through the walk and drain states, one result. Display and search: busy
// while walking every stored entry, then draining; display strobes one entry per cycle.
// Each entry goes through the single store read port; search uses the shared comparator.
// Reset (rst, synchronous) empties the queue and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// FIFO queue with search: top level
// Sequencer walking the ring store through one read port and one comparator.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_search_core_defines.svh"

module fifo_queue_with_search_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fqs_pkg::op_t     operation,
  input  fqs_pkg::word_t   value,
  output logic             busy,
  output logic             strobe,
  output fqs_pkg::status_t status,
  output fqs_pkg::word_t   data,
  output logic             found,
  output logic             last
);
  import fqs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  op_t        op;
  word_t      key;
  idx_t       head;
  cnt_t       fill_count;
  cnt_t       idx;
  logic       pend;
  logic       pend_last;
  logic       hit;
  logic       accept;
  logic       full;
  logic       match;
  wr_t        wr;
  rd_t        rd;
  word_t      rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (fill_count == CNT_W'(DEPTH));
  assign match  = (rdata == key);

  assign wr.en   = accept && (operation == OP_ENQ) && !full;
  assign wr.addr = slot_at(head, fill_count);
  assign wr.data = value;

  assign rd.en   = (state == S_WALK);
  assign rd.addr = slot_at(head, idx);

  fqs_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      fill_count <= '0;
      pend       <= 1'b0;
      pend_last  <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      pend      <= (state == S_WALK);
      pend_last <= (state == S_WALK) && (idx == '0);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_ENQ) begin
              strobe <= 1'b1;
              status <= full ? ST_FULL : ST_OK;
              data   <= '0;
              found  <= 1'b0;
              last   <= 1'b1;
              if (!full) begin
                fill_count <= fill_count + CNT_W'(1);
              end
            end else if (fill_count == '0) begin
              strobe <= 1'b1;
              status <= ST_EMPTY;
              data   <= '0;
              found  <= 1'b0;
              last   <= 1'b1;
            end else begin
              op    <= operation;
              key   <= value;
              hit   <= 1'b0;
              state <= S_WALK;
              unique case (operation) inside
                OP_DEQ:           idx <= '0;
                OP_SHOW, OP_FIND: idx <= fill_count - CNT_W'(1);
                default:          idx <= '0;
              endcase
            end
          end
        end
        S_WALK: begin
          if (idx == '0) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx - CNT_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
          if (op == OP_DEQ) begin
            head       <= slot_at(head, CNT_W'(1));
            fill_count <= fill_count - CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase

      // evaluate the entry read last cycle
      if (pend) begin
        if (op == OP_FIND) begin
          hit <= hit | match;
          if (pend_last) begin
            strobe <= 1'b1;
            status <= ST_OK;
            data   <= '0;
            found  <= hit | match;
            last   <= 1'b1;
          end
        end else begin
          strobe <= 1'b1;
          status <= ST_OK;
          data   <= rdata;
          found  <= 1'b0;
          last   <= pend_last;
        end
      end
    end
  end

  `FQS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill_count <= CNT_W'(DEPTH))
  `FQS_ASSERT_IMP(a_error_final, clk, rst, strobe && (status != ST_OK), last && (data == '0))
  `FQS_ASSERT_IMP(a_found_final, clk, rst, strobe && found, last && (status == ST_OK))
  `FQS_ASSERT_NXT(a_walk_starts, clk, rst,
    accept && (operation != OP_ENQ) && (fill_count != '0), busy)

endmodule

FILE: test/fifo_queue_with_search_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIFO queue with search: testbench
// Sends enqueue, display, dequeue and search transactions with random gaps,
// keeps its own copy of the ring to work out every result and checks each
// strobed result, field by field, against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core_tb;
  import fqs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    status_t status;
    word_t   data;
    logic    found;
    logic    last;
  } reply_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  op_t     operation = OP_ENQ;
  word_t   value = '0;
  logic    busy;
  logic    strobe;
  status_t status;
  word_t   data;
  logic    found;
  logic    last;

  word_t  ring [DEPTH];
  int     ring_head = 0;
  int     ring_fill = 0;
  reply_t reply_q [$];

  bit quiet = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int op_count [4] = '{default: 0};
  int full_drops = 0;
  int empty_replies = 0;
  int search_hits = 0;

  fifo_queue_with_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .status    (status),
    .data      (data),
    .found     (found),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void predict_queue(op_t op, word_t key);
    reply_t r;
    bit     hit;
    r = '{status: ST_OK, data: '0, found: 1'b0, last: 1'b1};
    hit = 1'b0;
    op_count[op]++;
    if (op == OP_ENQ) begin
      if (ring_fill >= DEPTH) begin
        r.status = ST_FULL;
        full_drops++;
      end else begin
        ring[(ring_head + ring_fill) % DEPTH] = key;
        ring_fill++;
      end
      reply_q.push_back(r);
    end else if (ring_fill == 0) begin
      r.status = ST_EMPTY;
      empty_replies++;
      reply_q.push_back(r);
    end else if (op == OP_SHOW) begin
      for (int k = ring_fill - 1; k >= 0; k--) begin
        r.data = ring[(ring_head + k) % DEPTH];
        r.last = (k == 0);
        reply_q.push_back(r);
      end
    end else if (op == OP_DEQ) begin
      r.data = ring[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
      reply_q.push_back(r);
    end else begin
      for (int k = 0; k < ring_fill; k++) begin
        if (ring[(ring_head + k) % DEPTH] === key) begin
          hit = 1'b1;
        end
      end
      r.found = hit;
      search_hits += hit;
      reply_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst && strobe) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: status %0d data %0d found %0d last %0d",
               status, data, found, last);
        errors++;
      end else begin
        want = reply_q.pop_front();
        results_seen++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, data);
          errors++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  task automatic send_item(op_t op, word_t key);
    int gap;
    gap = quiet ? 0 : $urandom_range(19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= key;
    do @(posedge clk); while (busy);
    predict_queue(op, key);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return word_t'($urandom_range(7)) - 4;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t search_key();
    if (ring_fill > 0 && $urandom_range(1)) begin
      return ring[(ring_head + $urandom_range(ring_fill - 1)) % DEPTH];
    end
    return pick_value();
  endfunction

  task automatic test_empty_queue();
    send_item(OP_SHOW, 32'sh7fff_ffff);
    send_item(OP_DEQ, 32'sh8000_0000);
    send_item(OP_FIND, '0);
  endtask

  task automatic test_fill_to_overflow();
    word_t corner_vals [6];
    corner_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                    32'sh5555_5555, 32'shaaaa_aaaa};
    for (int k = 0; k < DEPTH; k++) begin
      send_item(OP_ENQ, (k < 6) ? corner_vals[k] : word_t'($urandom));
    end
    send_item(OP_ENQ, 32'sh1234_5678);
    send_item(OP_SHOW, '0);
  endtask

  task automatic test_search_and_drain();
    send_item(OP_FIND, 32'sh8000_0000);
    send_item(OP_FIND, 32'sh1234_5678);
    send_item(OP_DEQ, -32'sd1);
    send_item(OP_DEQ, '0);
  endtask

  task automatic test_random_traffic(int count);
    int  fill_bias;
    int  roll;
    op_t op;
    fill_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        fill_bias = $urandom_range(20, 80);
        quiet = ($urandom_range(3) == 0);
      end
      roll = $urandom_range(99);
      if (roll < 15) begin
        op = OP_SHOW;
      end else if (roll < 35) begin
        op = OP_FIND;
      end else if ($urandom_range(99) < fill_bias) begin
        op = OP_ENQ;
      end else begin
        op = OP_DEQ;
      end
      send_item(op, (op == OP_FIND) ? search_key() : pick_value());
      if (n == count / 2) begin
        wait_drained();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_to_overflow();
    test_search_and_drain();
    wait_drained();
    test_random_traffic(395);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (reply_q.size() != 0) begin
      $error("%0d expected results never arrived", reply_q.size());
      errors++;
    end
    $display("Ran %0d enqueue, %0d display, %0d dequeue, %0d search transactions; %0d results",
             op_count[OP_ENQ], op_count[OP_SHOW], op_count[OP_DEQ], op_count[OP_FIND],
             results_seen);
    $display("Saw %0d full drops, %0d empty replies, %0d search hits",
             full_drops, empty_replies, search_hits);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
